@@ hdl/cell_density_bin_map_unit_defines.svh @@
// assertion macros used by the density map unit rtl
`ifndef CELL_DENSITY_BIN_MAP_UNIT_DEFINES_SVH
`define CELL_DENSITY_BIN_MAP_UNIT_DEFINES_SVH

// condition in this cycle implies property in this cycle
`define CDBM_ASSERT_SAME(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// condition in this cycle implies property in the next cycle
`define CDBM_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ hdl/cdbm_pkg.sv @@
// shared widths, coordinate type and helpers for the density map
`timescale 1ns / 1ps
`default_nettype none
package cdbm_pkg;

  // bin edge width and divider dividend width
  localparam int EW  = 16;
  localparam int DVW = 25;

  // signed coordinate wide enough for position plus size
  typedef logic signed [26:0] crd_t;

  function automatic crd_t crd_min(crd_t a, crd_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic crd_t crd_max(crd_t a, crd_t b);
    return (a > b) ? a : b;
  endfunction

endpackage
`default_nettype wire

@@ hdl/cdbm_ram.sv @@
// single write port, single read port memory with registered read data
`timescale 1ns / 1ps
`default_nettype none
module cdbm_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 48,
  parameter int AW    = 12
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ hdl/cdbm_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module cdbm_div import cdbm_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [DVW-1:0] dividend_i,
  input  wire logic [EW-1:0]  divisor_i,
  output logic                done_o,
  output logic      [DVW-1:0] quot_o,
  output logic      [EW-1:0]  rem_o
);

  localparam int CNW = $clog2(DVW);

  logic           busy_q;
  logic           done_q;
  logic [CNW-1:0] cnt_q;
  logic [DVW-1:0] quot_q;
  logic [EW-1:0]  rem_q;
  logic [EW:0]    trial;
  logic [EW:0]    diff;
  logic           ge;

  // one trial subtraction
  assign trial = {rem_q, quot_q[DVW-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNW'(DVW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // partial remainder and quotient shift
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[EW-1:0] : trial[EW-1:0];
      quot_q <= {quot_q[DVW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

@@ hdl/cell_density_bin_map_unit.sv @@
// density map over square bins: add cells, read bins, clear stores
// add item: clip and test, four divisions on the shared divider, a range step, then a row step per
//   covered row and overlap, multiply and write steps per covered bin, then the output register
// read: multiply, length, area, output steps, out of range straight on; a skipped add goes from the test
// to output; clear: all MAX_COLUMNS*MAX_ROWS entries; one item at a time; input stalls until the result
// is in the output register; reset: async active low, then a clearing pass over all entries, input stalled
`timescale 1ns / 1ps
`default_nettype none
`include "cell_density_bin_map_unit_defines.svh"
module cell_density_bin_map_unit import cdbm_pkg::*; #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic signed [23:0] pos_x_i,
  input  wire logic signed [23:0] pos_y_i,
  input  wire logic [23:0]        size_w_i,
  input  wire logic [23:0]        size_h_i,
  input  wire logic [2:0]         orient_i,
  input  wire logic               placed_i,
  input  wire logic [1:0]         cell_class_i,
  input  wire logic [1:0]         place_status_i,
  input  wire logic               is_macro_i,
  input  wire logic [5:0]         bin_column_i,
  input  wire logic [5:0]         bin_row_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [47:0]             movable_sum_o,
  output logic [31:0]             available_sum_o,
  output logic                    result_status_o
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CIW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_LIMIT_X  = 3'd2;
  localparam logic [2:0] CFG_LIMIT_Y  = 3'd3;
  localparam logic [2:0] CFG_BIN_EDGE = 3'd4;
  localparam logic [2:0] CFG_COLUMNS  = 3'd5;
  localparam logic [2:0] CFG_ROWS     = 3'd6;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ADD_PREP, S_ADD_TEST, S_DIV_GO, S_DIV_WAIT, S_RANGE, S_ROW,
    S_BIN_OVL, S_BIN_MUL, S_BIN_WR, S_RD_MUL, S_RD_LEN, S_RD_AREA, S_RD_OUT, S_FINISH
  } state_e;

  // configuration registers
  logic [23:0] origin_x_q, origin_y_q, limit_x_q, limit_y_q;
  logic [15:0] bin_edge_q;
  logic [6:0]  column_count_q, row_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q     <= '0;
      origin_y_q     <= '0;
      limit_x_q      <= '0;
      limit_y_q      <= '0;
      bin_edge_q     <= 16'd1;
      column_count_q <= 7'd1;
      row_count_q    <= 7'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ORIGIN_X: origin_x_q     <= cfg_data_i;
        CFG_ORIGIN_Y: origin_y_q     <= cfg_data_i;
        CFG_LIMIT_X:  limit_x_q      <= cfg_data_i;
        CFG_LIMIT_Y:  limit_y_q      <= cfg_data_i;
        CFG_BIN_EDGE: bin_edge_q     <= cfg_data_i[15:0];
        CFG_COLUMNS:  column_count_q <= cfg_data_i[6:0];
        CFG_ROWS:     row_count_q    <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // effective configuration
  logic [EW-1:0] e_eff;
  logic [6:0]    cols_lim, rows_lim;
  crd_t          ox, oy, lx, ly, e_crd;

  assign e_eff    = (bin_edge_q == '0) ? 16'd1 : bin_edge_q;
  assign cols_lim = (32'(column_count_q) > MAX_COLUMNS) ? 7'(MAX_COLUMNS) : column_count_q;
  assign rows_lim = (32'(row_count_q) > MAX_ROWS) ? 7'(MAX_ROWS) : row_count_q;
  assign ox       = {{3{origin_x_q[23]}}, origin_x_q};
  assign oy       = {{3{origin_y_q[23]}}, origin_y_q};
  assign lx       = {{3{limit_x_q[23]}}, limit_x_q};
  assign ly       = {{3{limit_y_q[23]}}, limit_y_q};
  assign e_crd    = {11'b0, e_eff};

  // control and datapath registers
  state_e         state_q;
  logic           clr_res_q;
  logic           out_valid_q;
  logic [AW-1:0]  clr_q;
  logic [1:0]     sel_q;

  logic [23:0]    pos_x_q, pos_y_q, size_w_q, size_h_q;
  logic [2:0]     orient_q;
  logic           placed_q, is_macro_q;
  logic [1:0]     cell_class_q, place_status_q;
  logic [5:0]     bin_column_q, bin_row_q;

  logic           skip_q, to_mov_q;
  crd_t           x0_q, x1_q, y0_q, y1_q, bx0_q, bx_q, by_q;
  logic [DVW-1:0] c0f_q, r0f_q, c1f_q, r1f_q;
  logic [CIW-1:0] c_q, c0_q, c1_q;
  logic [RIW-1:0] r_q, r1_q;
  logic [EW-1:0]  ow_q, oh_q, bw_q, bh_q;
  logic [21:0]    cx_q, ry_q;
  logic [31:0]    area_q;
  logic [AW-1:0]  addr_q;
  logic [47:0]    res_mov_q;
  logic [31:0]    res_av_q;
  logic           res_st_q;

  logic in_accept;
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // shared divider
  logic           div_start, div_done;
  logic [DVW-1:0] div_dvd, div_quot;
  logic [EW-1:0]  div_rem;
  crd_t           dvd_crd;

  always_comb begin
    case (sel_q)
      2'd0:    dvd_crd = x0_q - ox;
      2'd1:    dvd_crd = y0_q - oy;
      2'd2:    dvd_crd = x1_q - crd_t'(1) - ox;
      default: dvd_crd = y1_q - crd_t'(1) - oy;
    endcase
  end
  assign div_dvd   = dvd_crd[DVW-1:0];
  assign div_start = (state_q == S_DIV_GO);

  cdbm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (e_eff),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // stores
  logic          mov_we, blk_we, st_re;
  logic [AW-1:0] st_waddr;
  logic [47:0]   st_wdata, mov_rd, blk_rd;
  logic [48:0]   acc_sum;
  logic [47:0]   acc_sat;

  assign acc_sum  = {1'b0, (to_mov_q ? mov_rd : blk_rd)} + {17'b0, area_q};
  assign acc_sat  = acc_sum[48] ? '1 : acc_sum[47:0];
  assign st_waddr = (state_q == S_CLR) ? clr_q : addr_q;
  assign st_wdata = (state_q == S_CLR) ? '0 : acc_sat;
  assign mov_we   = (state_q == S_CLR) || ((state_q == S_BIN_WR) && to_mov_q);
  assign blk_we   = (state_q == S_CLR) || ((state_q == S_BIN_WR) && !to_mov_q);
  assign st_re    = (state_q == S_BIN_MUL) || (state_q == S_RD_MUL);

  cdbm_ram #(.DEPTH(DEPTH), .WIDTH(48), .AW(AW)) u_mov_ram (
    .clk_i   (clk_i),
    .we_i    (mov_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (addr_q),
    .rdata_o (mov_rd)
  );

  cdbm_ram #(.DEPTH(DEPTH), .WIDTH(48), .AW(AW)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (addr_q),
    .rdata_o (blk_rd)
  );

  // add item preparation: orientation swap and clipping
  logic [23:0] sw, sh;
  crd_t        xs, ys;
  assign sw = orient_q[0] ? size_h_q : size_w_q;
  assign sh = orient_q[0] ? size_w_q : size_h_q;
  assign xs = {{3{pos_x_q[23]}}, pos_x_q};
  assign ys = {{3{pos_y_q[23]}}, pos_y_q};

  // bin range after clamping to the grid
  logic [DVW-1:0] cmax, rmax, c1e, r1e;
  logic           range_empty;
  assign cmax        = DVW'(cols_lim) - DVW'(1);
  assign rmax        = DVW'(rows_lim) - DVW'(1);
  assign c1e         = (c1f_q > cmax) ? cmax : c1f_q;
  assign r1e         = (r1f_q > rmax) ? rmax : r1f_q;
  assign range_empty = (c0f_q > c1e) || (r0f_q > r1e);

  // overlap of the cell with the current bin
  crd_t ow_c, oh_c;
  assign ow_c = crd_min(x1_q, bx_q + e_crd) - crd_max(x0_q, bx_q);
  assign oh_c = crd_min(y1_q, by_q + e_crd) - crd_max(y0_q, by_q);

  // read item: clipped bin size
  crd_t bx_rd, by_rd, dw_rd, dh_rd;
  assign bx_rd = ox + crd_t'({5'b0, cx_q});
  assign by_rd = oy + crd_t'({5'b0, ry_q});
  assign dw_rd = lx - bx_rd;
  assign dh_rd = ly - by_rd;

  logic [47:0] area48, avail48;
  assign area48  = {16'b0, area_q};
  assign avail48 = (area48 > blk_rd) ? (area48 - blk_rd) : '0;

  logic res_load;
  assign res_load = (state_q == S_FINISH) && (!out_valid_q || !out_stall_i);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      clr_res_q   <= 1'b0;
      sel_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= clr_res_q ? S_FINISH : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            clr_q     <= '0;
            clr_res_q <= 1'b1;
            case (cmd_i)
              CMD_CLEAR: state_q <= S_CLR;
              CMD_ADD:   state_q <= S_ADD_PREP;
              CMD_READ:  state_q <= S_RD_MUL;
              default:   state_q <= S_FINISH;
            endcase
          end
        end
        S_ADD_PREP: state_q <= S_ADD_TEST;
        S_ADD_TEST: begin
          sel_q <= '0;
          if (skip_q || (x0_q >= x1_q) || (y0_q >= y1_q) ||
              (cols_lim == '0) || (rows_lim == '0)) begin
            state_q <= S_FINISH;
          end else begin
            state_q <= S_DIV_GO;
          end
        end
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            sel_q   <= sel_q + 1'b1;
            state_q <= (sel_q == 2'd3) ? S_RANGE : S_DIV_GO;
          end
        end
        S_RANGE:   state_q <= range_empty ? S_FINISH : S_ROW;
        S_ROW:     state_q <= S_BIN_OVL;
        S_BIN_OVL: state_q <= S_BIN_MUL;
        S_BIN_MUL: state_q <= S_BIN_WR;
        S_BIN_WR: begin
          if (c_q != c1_q) begin
            state_q <= S_BIN_OVL;
          end else if (r_q != r1_q) begin
            state_q <= S_ROW;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_RD_MUL: begin
          if (({1'b0, bin_column_q} >= cols_lim) || ({1'b0, bin_row_q} >= rows_lim)) begin
            state_q <= S_FINISH;
          end else begin
            state_q <= S_RD_LEN;
          end
        end
        S_RD_LEN:  state_q <= S_RD_AREA;
        S_RD_AREA: state_q <= S_RD_OUT;
        S_RD_OUT:  state_q <= S_FINISH;
        S_FINISH: begin
          if (res_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          pos_x_q        <= pos_x_i;
          pos_y_q        <= pos_y_i;
          size_w_q       <= size_w_i;
          size_h_q       <= size_h_i;
          orient_q       <= orient_i;
          placed_q       <= placed_i;
          cell_class_q   <= cell_class_i;
          place_status_q <= place_status_i;
          is_macro_q     <= is_macro_i;
          bin_column_q   <= bin_column_i;
          bin_row_q      <= bin_row_i;
          addr_q         <= AW'(32'(bin_row_i) * MAX_COLUMNS + 32'(bin_column_i));
          res_mov_q      <= '0;
          res_av_q       <= '0;
          res_st_q       <= 1'b0;
        end
      end
      S_ADD_PREP: begin
        skip_q   <= !placed_q || (cell_class_q == 2'd2) || (place_status_q == 2'd2) ||
                    (sw == '0) || (sh == '0);
        to_mov_q <= (cell_class_q == 2'd0) && (place_status_q == 2'd0) && !is_macro_q;
        x0_q     <= crd_max(xs, ox);
        y0_q     <= crd_max(ys, oy);
        x1_q     <= crd_min(xs + crd_t'({3'b0, sw}), lx);
        y1_q     <= crd_min(ys + crd_t'({3'b0, sh}), ly);
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          case (sel_q)
            2'd0: begin
              c0f_q <= div_quot;
              bx0_q <= x0_q - crd_t'({11'b0, div_rem});
            end
            2'd1: begin
              r0f_q <= div_quot;
              by_q  <= y0_q - crd_t'({11'b0, div_rem});
            end
            2'd2:    c1f_q <= div_quot;
            default: r1f_q <= div_quot;
          endcase
        end
      end
      S_RANGE: begin
        c0_q <= c0f_q[CIW-1:0];
        c1_q <= c1e[CIW-1:0];
        r_q  <= r0f_q[RIW-1:0];
        r1_q <= r1e[RIW-1:0];
      end
      S_ROW: begin
        oh_q <= oh_c[EW-1:0];
        c_q  <= c0_q;
        bx_q <= bx0_q;
      end
      S_BIN_OVL: begin
        ow_q   <= ow_c[EW-1:0];
        addr_q <= AW'(32'(r_q) * MAX_COLUMNS + 32'(c_q));
      end
      S_BIN_MUL: area_q <= 32'(ow_q) * 32'(oh_q);
      S_BIN_WR: begin
        if (c_q != c1_q) begin
          c_q  <= c_q + 1'b1;
          bx_q <= bx_q + e_crd;
        end else begin
          r_q  <= r_q + 1'b1;
          by_q <= by_q + e_crd;
        end
      end
      S_RD_MUL: begin
        cx_q <= 22'(bin_column_q) * 22'(e_eff);
        ry_q <= 22'(bin_row_q) * 22'(e_eff);
        if (({1'b0, bin_column_q} >= cols_lim) || ({1'b0, bin_row_q} >= rows_lim)) begin
          res_st_q <= 1'b1;
        end
      end
      S_RD_LEN: begin
        bw_q <= (dw_rd < 0) ? '0 : ((dw_rd > e_crd) ? e_eff : dw_rd[EW-1:0]);
        bh_q <= (dh_rd < 0) ? '0 : ((dh_rd > e_crd) ? e_eff : dh_rd[EW-1:0]);
      end
      S_RD_AREA: area_q <= 32'(bw_q) * 32'(bh_q);
      S_RD_OUT: begin
        res_mov_q <= mov_rd;
        res_av_q  <= avail48[31:0];
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      movable_sum_o   <= res_mov_q;
      available_sum_o <= res_av_q;
      result_status_o <= res_st_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `CDBM_ASSERT_SAME(a_idle_no_write, state_q == S_IDLE, !mov_we && !blk_we, "store written while idle")
  `CDBM_ASSERT_SAME(a_walk_in_range, state_q == S_BIN_WR, c_q <= c1_q && r_q <= r1_q, "bin walk past range")
  `CDBM_ASSERT_SAME(a_overlap_nonzero, state_q == S_BIN_MUL, ow_q != '0 && oh_q != '0, "empty bin overlap")
  `CDBM_ASSERT_SAME(a_div_done_wait, div_done, state_q == S_DIV_WAIT, "divider done outside wait")
  `CDBM_ASSERT_NEXT(a_accept_busy, in_accept, in_stall_o, "input not stalled after accept")

endmodule
`default_nettype wire

@@ tb/cell_density_bin_map_unit_tb.sv @@
// testbench for the cell density bin map: directed table, random phases, predictor check
`timescale 1ns / 1ps
module cell_density_bin_map_unit_tb;
  import cdbm_pkg::*;

  // command, class, status, orientation and register codes
  localparam logic [1:0] CMD_CLEAR = 2'd0, CMD_ADD = 2'd1, CMD_READ = 2'd2, CMD_NONE = 2'd3;
  localparam logic [1:0] CLS_MOVABLE = 2'd0, CLS_TERM = 2'd1, CLS_TERM_NI = 2'd2, CLS_ODD = 2'd3;
  localparam logic [1:0] ST_MOVABLE = 2'd0, ST_FIXED = 2'd1, ST_FIXED_NI = 2'd2, ST_ODD = 2'd3;
  localparam logic [2:0] ORI_N = 3'd0, ORI_E = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X = 3'd0, REG_ORIGIN_Y = 3'd1, REG_LIMIT_X = 3'd2,
                         REG_LIMIT_Y = 3'd3, REG_BIN_EDGE = 3'd4, REG_COLUMNS = 3'd5,
                         REG_ROWS = 3'd6;
  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;
  localparam logic [47:0] AREA_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [23:0] px, py;
    logic [23:0]        sw, sh;
    logic [2:0]         ori;
    logic               pl;
    logic [1:0]         cls, st;
    logic               mac;
    logic [5:0]         col, row;
    bit                 typed;
    logic [47:0]        e_mov;
    logic [31:0]        e_avl;
    logic               e_stat;
  } cell_item_t;

  typedef struct {
    logic [47:0] mov;
    logic [31:0] avl;
    logic        stat;
  } bin_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] cmd_i = '0;
  logic signed [23:0] pos_x_i = '0, pos_y_i = '0;
  logic [23:0] size_w_i = '0, size_h_i = '0;
  logic [2:0] orient_i = '0;
  logic placed_i = 1'b0;
  logic [1:0] cell_class_i = '0, place_status_i = '0;
  logic is_macro_i = 1'b0;
  logic [5:0] bin_column_i = '0, bin_row_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [47:0] movable_sum_o;
  logic [31:0] available_sum_o;
  logic result_status_o;

  cell_density_bin_map_unit dut (.*);

  // own copy of configuration and both area stores
  longint m_ox, m_oy, m_lx, m_ly, m_edge, m_cols, m_rows;
  logic [47:0] mov_area [GRID_COLS*GRID_ROWS];
  logic [47:0] blk_area [GRID_COLS*GRID_ROWS];

  bin_result_t expected_bins[$];
  cell_item_t cur_item;
  bin_result_t pred;
  int errs = 0, n_add = 0, n_read = 0, n_clear = 0, n_phase = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // overall time limit
  initial begin
    #10ms;
    $display("cell_density_bin_map_unit_tb: errors");
    $finish;
  end

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic longint clip_len(longint start, longint lim, longint e);
    longint d;
    d = lim - start;
    if (d < 0) return 0;
    return d > e ? e : d;
  endfunction

  // density map prediction for one item, updates the stores
  function automatic bin_result_t apply_item(cell_item_t it);
    longint e, cmax, rmax, x, y, w, h, t, x0, x1, y0, y1, c0, c1, r0, r1, ow, oh;
    longint bw, bh, area, s;
    int idx;
    bit to_mov;
    bin_result_t res;
    res = '{mov: '0, avl: '0, stat: 1'b0};
    e = (m_edge == 0) ? 1 : m_edge;
    cmax = (m_cols > GRID_COLS) ? GRID_COLS : m_cols;
    rmax = (m_rows > GRID_ROWS) ? GRID_ROWS : m_rows;
    case (it.cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < GRID_COLS*GRID_ROWS; i++) begin
          mov_area[i] = '0;
          blk_area[i] = '0;
        end
      end
      CMD_ADD: begin
        w = longint'(it.sw);
        h = longint'(it.sh);
        if (it.ori[0]) begin
          t = w; w = h; h = t;
        end
        x = longint'(it.px);
        y = longint'(it.py);
        if (it.pl && it.cls != CLS_TERM_NI && it.st != ST_FIXED_NI && w != 0 && h != 0) begin
          to_mov = (it.cls == CLS_MOVABLE) && (it.st == ST_MOVABLE) && !it.mac;
          x0 = lmax(x, m_ox);
          y0 = lmax(y, m_oy);
          x1 = lmin(x + w, m_lx);
          y1 = lmin(y + h, m_ly);
          if (x0 < x1 && y0 < y1) begin
            c0 = (x0 - m_ox) / e;
            r0 = (y0 - m_oy) / e;
            c1 = lmin(cmax - 1, (x1 - 1 - m_ox) / e);
            r1 = lmin(rmax - 1, (y1 - 1 - m_oy) / e);
            for (longint r = r0; r <= r1; r++) begin
              oh = lmin(y1, m_oy + r*e + e) - lmax(y0, m_oy + r*e);
              for (longint c = c0; c <= c1; c++) begin
                ow = lmin(x1, m_ox + c*e + e) - lmax(x0, m_ox + c*e);
                idx = int'(r*GRID_COLS + c);
                if (to_mov) begin
                  s = longint'(mov_area[idx]) + ow*oh;
                  mov_area[idx] = (s > longint'(AREA_MAX)) ? AREA_MAX : s[47:0];
                end else begin
                  s = longint'(blk_area[idx]) + ow*oh;
                  blk_area[idx] = (s > longint'(AREA_MAX)) ? AREA_MAX : s[47:0];
                end
              end
            end
          end
        end
      end
      CMD_READ: begin
        if (longint'(it.col) >= cmax || longint'(it.row) >= rmax) begin
          res.stat = 1'b1;
        end else begin
          idx = it.row*GRID_COLS + it.col;
          bw = clip_len(m_ox + longint'(it.col)*e, m_lx, e);
          bh = clip_len(m_oy + longint'(it.row)*e, m_ly, e);
          area = bw*bh;
          res.mov = mov_area[idx];
          s = (area > longint'(blk_area[idx])) ? area - longint'(blk_area[idx]) : 0;
          res.avl = s[31:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // register write, mirrored into the predictor
  task automatic cfg_write(logic [2:0] idx, logic [23:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ORIGIN_X: m_ox = longint'($signed(value));
      REG_ORIGIN_Y: m_oy = longint'($signed(value));
      REG_LIMIT_X:  m_lx = longint'($signed(value));
      REG_LIMIT_Y:  m_ly = longint'($signed(value));
      REG_BIN_EDGE: m_edge = longint'(value[15:0]);
      REG_COLUMNS:  m_cols = longint'(value[6:0]);
      REG_ROWS:     m_rows = longint'(value[6:0]);
      default: ;
    endcase
  endtask

  task automatic set_region(longint ox, longint oy, longint lx, longint ly, longint e,
                            longint cols, longint rows);
    // drop the last item and wait for the block to drain before touching registers
    in_valid_i <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_write(REG_ORIGIN_X, ox[23:0]);
    cfg_write(REG_ORIGIN_Y, oy[23:0]);
    cfg_write(REG_LIMIT_X, lx[23:0]);
    cfg_write(REG_LIMIT_Y, ly[23:0]);
    cfg_write(REG_BIN_EDGE, {8'd0, e[15:0]});
    cfg_write(REG_COLUMNS, {17'd0, cols[6:0]});
    cfg_write(REG_ROWS, {17'd0, rows[6:0]});
    n_phase++;
  endtask

  // drive one item and hold it until accepted, then maybe idle
  task automatic send(cell_item_t it);
    int gap;
    cmd_i <= it.cmd;
    pos_x_i <= it.px;
    pos_y_i <= it.py;
    size_w_i <= it.sw;
    size_h_i <= it.sh;
    orient_i <= it.ori;
    placed_i <= it.pl;
    cell_class_i <= it.cls;
    place_status_i <= it.st;
    is_macro_i <= it.mac;
    bin_column_i <= it.col;
    bin_row_i <= it.row;
    cur_item <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = int'($urandom_range(1, 9));
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic cell_item_t mk(logic [1:0] cmd, longint px, longint py, longint sw,
                                    longint sh, logic [2:0] ori, logic pl, logic [1:0] cls,
                                    logic [1:0] st, logic mac, int col, int row);
    cell_item_t it;
    it.cmd = cmd; it.px = px[23:0]; it.py = py[23:0]; it.sw = sw[23:0]; it.sh = sh[23:0];
    it.ori = ori; it.pl = pl; it.cls = cls; it.st = st; it.mac = mac;
    it.col = col[5:0]; it.row = row[5:0];
    it.typed = 1'b0; it.e_mov = '0; it.e_avl = '0; it.e_stat = 1'b0;
    return it;
  endfunction

  function automatic cell_item_t fixed_res(cell_item_t it, logic [47:0] mv, logic [31:0] av,
                                           logic stt);
    it.typed = 1'b1; it.e_mov = mv; it.e_avl = av; it.e_stat = stt;
    return it;
  endfunction

  // random item shaped around the current region
  function automatic cell_item_t rand_item(bit wide);
    cell_item_t it;
    longint e, spx, spy, cmax, rmax;
    int r;
    e = (m_edge == 0) ? 1 : m_edge;
    spx = lmax(m_lx - m_ox, 0);
    spy = lmax(m_ly - m_oy, 0);
    cmax = (m_cols > GRID_COLS) ? GRID_COLS : m_cols;
    rmax = (m_rows > GRID_ROWS) ? GRID_ROWS : m_rows;
    it = mk(CMD_READ, 0, 0, 0, 0, ORI_N, 1'b1, CLS_MOVABLE, ST_MOVABLE, 1'b0, 0, 0);
    r = int'($urandom_range(0, 99));
    it.cmd = (r < 1) ? CMD_CLEAR : (r < 3) ? CMD_NONE : (r < 55) ? CMD_ADD : CMD_READ;
    if (wide) begin
      it.px = 24'($urandom());
      it.py = 24'($urandom());
    end else begin
      it.px = 24'(m_ox - 2*e + longint'($urandom_range(0, int'(spx + 4*e))));
      it.py = 24'(m_oy - 2*e + longint'($urandom_range(0, int'(spy + 4*e))));
    end
    it.sw = 24'($urandom_range(0, int'(3*e)));
    it.sh = 24'($urandom_range(0, int'(3*e)));
    if (wide && $urandom_range(0, 49) == 0) begin
      it.sw = 24'($urandom());
      it.sh = 24'($urandom());
    end
    it.ori = 3'($urandom_range(0, 7));
    it.pl = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 1) == 0) begin
      it.cls = CLS_MOVABLE; it.st = ST_MOVABLE; it.mac = 1'b0;
    end else begin
      it.cls = 2'($urandom_range(0, 3));
      it.st = 2'($urandom_range(0, 3));
      it.mac = 1'($urandom_range(0, 1));
    end
    if ($urandom_range(0, 9) < 7 && cmax > 0 && rmax > 0) begin
      it.col = 6'($urandom_range(0, int'(cmax - 1)));
      it.row = 6'($urandom_range(0, int'(rmax - 1)));
    end else begin
      it.col = 6'($urandom_range(0, 63));
      it.row = 6'($urandom_range(0, 63));
    end
    return it;
  endfunction

  task automatic run_random(int count, bit wide);
    cell_item_t it;
    for (int i = 0; i < count; i++) begin
      it = rand_item(wide);
      send(it);
    end
  endtask

  // predict on acceptance
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pred = apply_item(cur_item);
      if (cur_item.typed) pred = '{mov: cur_item.e_mov, avl: cur_item.e_avl,
                                    stat: cur_item.e_stat};
      expected_bins.push_back(pred);
      case (cur_item.cmd)
        CMD_ADD:   n_add++;
        CMD_READ:  n_read++;
        CMD_CLEAR: n_clear++;
        default: ;
      endcase
    end
  end

  // compare results against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_bins.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result mov=%0d avl=%0d st=%0d",
                                 movable_sum_o, available_sum_o, result_status_o);
      end else begin
        pred = expected_bins.pop_front();
        if (movable_sum_o !== pred.mov || available_sum_o !== pred.avl ||
            result_status_o !== pred.stat) begin
          errs++;
          if (errs <= 10)
            $display("mismatch: exp mov=%0d avl=%0d st=%0d, got mov=%0d avl=%0d st=%0d",
                     pred.mov, pred.avl, pred.stat, movable_sum_o, available_sum_o,
                     result_status_o);
        end
      end
    end
  end

  // receiver stall bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= int'($urandom_range(0, 8));
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // stimulus
  initial begin
    cell_item_t dir_tab[$];
    longint e, ox, oy, cols, rows;
    m_ox = 0; m_oy = 0; m_lx = 0; m_ly = 0; m_edge = 1; m_cols = 1; m_rows = 1;
    for (int i = 0; i < GRID_COLS*GRID_ROWS; i++) begin
      mov_area[i] = '0;
      blk_area[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);

    // empty region straight after reset
    dir_tab.push_back(fixed_res(mk(CMD_READ, 0, 0, 0, 0, ORI_N, 1, CLS_MOVABLE, ST_MOVABLE,
                                   0, 0, 0), 0, 0, 0));
    dir_tab.push_back(fixed_res(mk(CMD_READ, 0, 0, 0, 0, ORI_N, 1, CLS_MOVABLE, ST_MOVABLE,
                                   0, 1, 0), 0, 0, 1));
    dir_tab.push_back(fixed_res(mk(CMD_ADD, 0, 0, 5, 5, ORI_N, 1, CLS_MOVABLE, ST_MOVABLE,
                                   0, 0, 0), 0, 0, 0));
    foreach (dir_tab[i]) send(dir_tab[i]);
    dir_tab.delete();

    // small 10 by 10 grid, last column half cut by the region
    set_region(0, 0, 95, 100, 10, 10, 10);
    dir_tab.push_back(fixed_res(mk(CMD_READ, 0, 0, 0, 0, ORI_N, 1, 0, 0, 0, 0, 0), 0, 100, 0));
    dir_tab.push_back(fixed_res(mk(CMD_READ, 0, 0, 0, 0, ORI_N, 1, 0, 0, 0, 9, 0), 0, 50, 0));
    dir_tab.push_back(fixed_res(mk(CMD_READ, 0, 0, 0, 0, ORI_N, 1, 0, 0, 0, 10, 0), 0, 0, 1));
    dir_tab.push_back(fixed_res(mk(CMD_READ, 0, 0, 0, 0, ORI_N, 1, 0, 0, 0, 63, 63), 0, 0, 1));
    dir_tab.push_back(mk(CMD_ADD, 5, 5, 10, 10, ORI_N, 1, CLS_MOVABLE, ST_MOVABLE, 0, 0, 0));
    dir_tab.push_back(mk(CMD_ADD, 0, 0, 10, 10, ORI_N, 1, CLS_TERM, ST_FIXED, 0, 0, 0));
    dir_tab.push_back(mk(CMD_ADD, 12, 3, 30, 5, ORI_E, 1, CLS_MOVABLE, ST_MOVABLE, 1, 0, 0));
    dir_tab.push_back(mk(CMD_ADD, 0, 0, 10, 10, ORI_N, 0, CLS_MOVABLE, ST_MOVABLE, 0, 0, 0));
    dir_tab.push_back(mk(CMD_ADD, 0, 0, 10, 10, ORI_N, 1, CLS_TERM_NI, ST_FIXED, 0, 0, 0));
    dir_tab.push_back(mk(CMD_ADD, 0, 0, 10, 10, ORI_N, 1, CLS_TERM, ST_FIXED_NI, 0, 0, 0));
    dir_tab.push_back(mk(CMD_ADD, 20, 20, 7, 9, 3'd6, 1, CLS_ODD, ST_ODD, 0, 0, 0));
    dir_tab.push_back(mk(CMD_ADD, 30, 30, 0, 9, ORI_N, 1, CLS_MOVABLE, ST_MOVABLE, 0, 0, 0));
    dir_tab.push_back(mk(CMD_ADD, -500, -500, 9, 9, ORI_N, 1, CLS_MOVABLE, ST_MOVABLE, 0, 0, 0));
    dir_tab.push_back(mk(CMD_ADD, -8388608, -8388608, 24'hFFFFFF, 24'hFFFFFF, 3'd7, 1,
                         CLS_TERM, ST_MOVABLE, 0, 0, 0));
    dir_tab.push_back(mk(CMD_ADD, 8388607, 8388607, 3, 3, ORI_N, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(fixed_res(mk(CMD_NONE, 1, 1, 5, 5, ORI_N, 1, 0, 0, 0, 1, 1), 0, 0, 0));
    dir_tab.push_back(mk(CMD_READ, 0, 0, 0, 0, ORI_N, 1, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(CMD_READ, 0, 0, 0, 0, ORI_N, 1, 0, 0, 0, 1, 1));
    dir_tab.push_back(mk(CMD_READ, 0, 0, 0, 0, ORI_N, 1, 0, 0, 0, 9, 9));
    dir_tab.push_back(fixed_res(mk(CMD_CLEAR, 0, 0, 0, 0, ORI_N, 1, 0, 0, 0, 0, 0), 0, 0, 0));
    dir_tab.push_back(fixed_res(mk(CMD_READ, 0, 0, 0, 0, ORI_N, 1, 0, 0, 0, 0, 0), 0, 100, 0));
    foreach (dir_tab[i]) send(dir_tab[i]);

    // extreme region: full coordinate span, widest bins, full grid
    set_region(-8388608, -8388608, 8388607, 8388607, 65535, 64, 64);
    run_random(140, 1'b1);
    // zero edge and counts beyond the grid limit
    set_region(-100, 50, -60, 90, 0, 127, 127);
    run_random(140, 1'b0);
    // no columns and an empty region
    set_region(1000, 1000, 900, 1200, 20, 0, 5);
    run_random(60, 1'b0);
    // random regions, the last one without idling
    for (int p = 0; p < 6; p++) begin
      e = $urandom_range(1, 400);
      cols = $urandom_range(1, 64);
      rows = $urandom_range(1, 64);
      ox = longint'($urandom_range(0, 8000000)) - 4000000;
      oy = longint'($urandom_range(0, 8000000)) - 4000000;
      set_region(ox, oy, ox + cols*e - $urandom_range(0, int'(e - 1)),
                 oy + rows*e - $urandom_range(0, int'(e - 1)), e, cols, rows);
      if (p == 5) idle_on = 1'b0;
      run_random(135, 1'b0);
    end
    in_valid_i <= 1'b0;

    while (expected_bins.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (expected_bins.size() != 0) errs++;
    $display("covered %0d adds, %0d reads, %0d clears over %0d region settings",
             n_add, n_read, n_clear, n_phase);
    if (errs > 10) $display("%0d mismatches in total", errs);
    if (errs == 0) begin
      $display("cell_density_bin_map_unit_tb: clean");
    end else begin
      $display("cell_density_bin_map_unit_tb: errors");
    end
    $finish;
  end

endmodule
